FILE: hdl/amx_pkg.sv
// shared types, constants and the microcode table of the affine matrix inverse
`default_nettype none
package amx_pkg;

  localparam int DATA_W = 32;
  localparam int ELEMS  = 12;
  localparam int IDX_W  = 4;
  localparam int OP_W   = 33;
  localparam int PROD_W = 66;
  localparam int ACC_W  = 100;
  localparam int NUM_W  = 136;
  localparam int QW     = 35;
  localparam int UOP_N  = 42;
  localparam int UOP_W  = 6;
  localparam logic [IDX_W-1:0] DET_IDX  = 4'd12;
  localparam logic [IDX_W-1:0] LAST_IDX = 4'd11;
  localparam logic [IDX_W-1:0] TRANS_IDX = 4'd9;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [NUM_W-1:0] num_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_RDA, ST_RDB, ST_MUL, ST_ACC, ST_WB, ST_DRD, ST_DIV, ST_WAIT, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {B_EL, B_HI, B_LO} bsel_e;

  typedef struct packed {
    logic [IDX_W-1:0] a_idx;
    bsel_e            b_sel;
    logic [IDX_W-1:0] b_idx;
    logic             sub;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] dest;
  } uop_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic first;
    logic sub;
    logic shl32;
  } mac_ctrl_t;

  // cofactors (pairs), translation terms and determinant (hi/lo limb pairs)
  localparam uop_t UOP_TABLE [UOP_N] = '{
    '{4'd4, B_EL, 4'd8, 1'b0, 1'b1, 1'b0, 4'd0},
    '{4'd5, B_EL, 4'd7, 1'b1, 1'b0, 1'b1, 4'd0},
    '{4'd3, B_EL, 4'd8, 1'b0, 1'b1, 1'b0, 4'd3},
    '{4'd5, B_EL, 4'd6, 1'b1, 1'b0, 1'b1, 4'd3},
    '{4'd3, B_EL, 4'd7, 1'b0, 1'b1, 1'b0, 4'd6},
    '{4'd4, B_EL, 4'd6, 1'b1, 1'b0, 1'b1, 4'd6},
    '{4'd1, B_EL, 4'd8, 1'b0, 1'b1, 1'b0, 4'd1},
    '{4'd2, B_EL, 4'd7, 1'b1, 1'b0, 1'b1, 4'd1},
    '{4'd0, B_EL, 4'd8, 1'b0, 1'b1, 1'b0, 4'd4},
    '{4'd2, B_EL, 4'd6, 1'b1, 1'b0, 1'b1, 4'd4},
    '{4'd0, B_EL, 4'd7, 1'b0, 1'b1, 1'b0, 4'd7},
    '{4'd1, B_EL, 4'd6, 1'b1, 1'b0, 1'b1, 4'd7},
    '{4'd1, B_EL, 4'd5, 1'b0, 1'b1, 1'b0, 4'd2},
    '{4'd2, B_EL, 4'd4, 1'b1, 1'b0, 1'b1, 4'd2},
    '{4'd0, B_EL, 4'd5, 1'b0, 1'b1, 1'b0, 4'd5},
    '{4'd2, B_EL, 4'd3, 1'b1, 1'b0, 1'b1, 4'd5},
    '{4'd0, B_EL, 4'd4, 1'b0, 1'b1, 1'b0, 4'd8},
    '{4'd1, B_EL, 4'd3, 1'b1, 1'b0, 1'b1, 4'd8},
    '{4'd9,  B_HI, 4'd0, 1'b0, 1'b1, 1'b0, 4'd9},
    '{4'd9,  B_LO, 4'd0, 1'b0, 1'b0, 1'b0, 4'd9},
    '{4'd10, B_HI, 4'd3, 1'b1, 1'b0, 1'b0, 4'd9},
    '{4'd10, B_LO, 4'd3, 1'b1, 1'b0, 1'b0, 4'd9},
    '{4'd11, B_HI, 4'd6, 1'b0, 1'b0, 1'b0, 4'd9},
    '{4'd11, B_LO, 4'd6, 1'b0, 1'b0, 1'b1, 4'd9},
    '{4'd9,  B_HI, 4'd1, 1'b0, 1'b1, 1'b0, 4'd10},
    '{4'd9,  B_LO, 4'd1, 1'b0, 1'b0, 1'b0, 4'd10},
    '{4'd10, B_HI, 4'd4, 1'b1, 1'b0, 1'b0, 4'd10},
    '{4'd10, B_LO, 4'd4, 1'b1, 1'b0, 1'b0, 4'd10},
    '{4'd11, B_HI, 4'd7, 1'b0, 1'b0, 1'b0, 4'd10},
    '{4'd11, B_LO, 4'd7, 1'b0, 1'b0, 1'b1, 4'd10},
    '{4'd9,  B_HI, 4'd2, 1'b0, 1'b1, 1'b0, 4'd11},
    '{4'd9,  B_LO, 4'd2, 1'b0, 1'b0, 1'b0, 4'd11},
    '{4'd10, B_HI, 4'd5, 1'b1, 1'b0, 1'b0, 4'd11},
    '{4'd10, B_LO, 4'd5, 1'b1, 1'b0, 1'b0, 4'd11},
    '{4'd11, B_HI, 4'd8, 1'b0, 1'b0, 1'b0, 4'd11},
    '{4'd11, B_LO, 4'd8, 1'b0, 1'b0, 1'b1, 4'd11},
    '{4'd0, B_HI, 4'd0, 1'b0, 1'b1, 1'b0, 4'd12},
    '{4'd0, B_LO, 4'd0, 1'b0, 1'b0, 1'b0, 4'd12},
    '{4'd1, B_HI, 4'd3, 1'b1, 1'b0, 1'b0, 4'd12},
    '{4'd1, B_LO, 4'd3, 1'b1, 1'b0, 1'b0, 4'd12},
    '{4'd2, B_HI, 4'd6, 1'b0, 1'b0, 1'b0, 4'd12},
    '{4'd2, B_LO, 4'd6, 1'b0, 1'b0, 1'b1, 4'd12}
  };

endpackage
`default_nettype wire

FILE: hdl/amx_mac.sv
// shared signed multiply-accumulate unit
`default_nettype none
module amx_mac (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire amx_pkg::mac_ctrl_t         ctrl_i,
  input  wire logic signed [amx_pkg::OP_W-1:0] opa_i,
  input  wire logic signed [amx_pkg::OP_W-1:0] opb_i,
  output logic signed [amx_pkg::ACC_W-1:0]     acc_o
);

  amx_pkg::prod_t prod_q;
  amx_pkg::acc_t  acc_q, acc_d, term, base;

  always_comb begin
    term = ctrl_i.shl32 ? (amx_pkg::acc_t'(prod_q) <<< 32) : amx_pkg::acc_t'(prod_q);
    base = ctrl_i.first ? '0 : acc_q;
    acc_d = ctrl_i.sub ? (base - term) : (base + term);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      if (ctrl_i.mul_en) begin
        prod_q <= opa_i * opb_i;
      end
      if (ctrl_i.acc_en) begin
        acc_q <= acc_d;
      end
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

FILE: hdl/amx_div.sv
// restoring divider, one quotient bit per cycle, signed saturation to 32 bits
`default_nettype none
module amx_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [amx_pkg::NUM_W-1:0]   num_i,
  input  wire logic [amx_pkg::NUM_W-1:0]   den_i,
  input  wire logic                        neg_i,
  output logic                             done_o,
  output logic [amx_pkg::DATA_W-1:0]       quot_o
);

  logic [amx_pkg::NUM_W-1:0] rem_q, dsh_q;
  logic [amx_pkg::QW-1:0]    q_q;
  logic                      neg_q;
  logic [5:0]                cnt_q;
  logic                      run_q, done_q;
  logic                      ge;

  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'(amx_pkg::QW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= den_i << (amx_pkg::QW - 1);
      q_q   <= '0;
      neg_q <= neg_i;
    end else if (run_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      q_q   <= {q_q[amx_pkg::QW-2:0], ge};
    end
  end

  // saturate to the signed 32-bit range
  always_comb begin
    if (!neg_q) begin
      quot_o = (|q_q[amx_pkg::QW-1:31]) ? 32'h7FFF_FFFF : q_q[31:0];
    end else if ((|q_q[amx_pkg::QW-1:32]) || (q_q[31] && (|q_q[30:0]))) begin
      quot_o = 32'h8000_0000;
    end else begin
      quot_o = 32'd0 - q_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

FILE: hdl/affine_matrix_inverse_core.sv
// affine 3x4 matrix inverse by adjugate: loader, microcoded sequencer, mac and divider
// sequence: twelve requests load one per cycle while idle; then 42 microcode steps, each through the
//   read, read, multiply and accumulate states, plus 13 write-backs, on the shared multiply-accumulate
//   unit; then per result a read, a divider start, the divider run and an emit, with the divider
//   skipped for a singular matrix
// a new matrix is taken only after the last result has been emitted and busy is low
// reset: asynchronous, clears the sequencer and load count; results are never stalled
`default_nettype none
module affine_matrix_inverse_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [31:0] element_value_i,
  output logic             result_valid_o,
  output logic signed [31:0] inverse_value_o,
  output logic             is_last_o,
  output logic             singular_o
);

  // sequencer state
  amx_pkg::state_e state_q, state_d;
  logic [amx_pkg::IDX_W-1:0] load_cnt_q;
  logic [amx_pkg::UOP_W-1:0] uop_q;
  logic [amx_pkg::IDX_W-1:0] k_q;
  logic                      det_zero_q;
  amx_pkg::uop_t             uop;

  // source elements and the exact adjugate entries
  logic [31:0]               store_q [amx_pkg::ELEMS];
  amx_pkg::acc_t             res_q   [amx_pkg::ELEMS];
  logic [31:0]               rd_q, opa_q;
  amx_pkg::acc_t             rres_q, det_q;
  logic [amx_pkg::IDX_W-1:0] st_addr, res_addr;

  // shared units
  amx_pkg::mac_ctrl_t        mac_ctrl;
  logic signed [amx_pkg::OP_W-1:0] opa, opb;
  amx_pkg::acc_t             acc;
  logic                      div_start, div_done;
  logic [31:0]               quot;
  logic [amx_pkg::NUM_W-1:0] num, den;
  logic [amx_pkg::ACC_W-1:0] num_mag, det_mag;
  logic                      num_neg;
  logic                      accept;

  assign uop    = amx_pkg::UOP_TABLE[uop_q];
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      amx_pkg::ST_LOAD: if (accept && load_cnt_q == amx_pkg::LAST_IDX) begin
        state_d = amx_pkg::ST_RDA;
      end
      amx_pkg::ST_RDA:  state_d = amx_pkg::ST_RDB;
      amx_pkg::ST_RDB:  state_d = amx_pkg::ST_MUL;
      amx_pkg::ST_MUL:  state_d = amx_pkg::ST_ACC;
      amx_pkg::ST_ACC:  state_d = uop.last ? amx_pkg::ST_WB : amx_pkg::ST_RDA;
      amx_pkg::ST_WB:   state_d = (uop_q == 6'(amx_pkg::UOP_N - 1)) ? amx_pkg::ST_DRD
                                                                    : amx_pkg::ST_RDA;
      amx_pkg::ST_DRD:  state_d = amx_pkg::ST_DIV;
      amx_pkg::ST_DIV:  state_d = det_zero_q ? amx_pkg::ST_EMIT : amx_pkg::ST_WAIT;
      amx_pkg::ST_WAIT: if (div_done) begin
        state_d = amx_pkg::ST_EMIT;
      end
      amx_pkg::ST_EMIT: state_d = (k_q == amx_pkg::LAST_IDX) ? amx_pkg::ST_LOAD
                                                            : amx_pkg::ST_DRD;
      default:          state_d = amx_pkg::ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy              = state_q != amx_pkg::ST_LOAD;
    result_valid_o    = state_q == amx_pkg::ST_EMIT;
    div_start         = (state_q == amx_pkg::ST_DIV) && !det_zero_q;
    mac_ctrl.mul_en   = state_q == amx_pkg::ST_MUL;
    mac_ctrl.acc_en   = state_q == amx_pkg::ST_ACC;
    mac_ctrl.first    = uop.first;
    mac_ctrl.sub      = uop.sub;
    mac_ctrl.shl32    = uop.b_sel == amx_pkg::B_HI;
    st_addr           = (state_q == amx_pkg::ST_RDA) ? uop.a_idx : uop.b_idx;
    res_addr          = (state_q == amx_pkg::ST_RDB) ? uop.b_idx : k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= amx_pkg::ST_LOAD;
      load_cnt_q <= '0;
      uop_q      <= '0;
      k_q        <= '0;
      det_zero_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        load_cnt_q <= (load_cnt_q == amx_pkg::LAST_IDX) ? '0 : load_cnt_q + 4'd1;
        uop_q      <= '0;
      end
      if (state_q == amx_pkg::ST_ACC && !uop.last) begin
        uop_q <= uop_q + 6'd1;
      end
      if (state_q == amx_pkg::ST_WB) begin
        if (uop_q != 6'(amx_pkg::UOP_N - 1)) begin
          uop_q <= uop_q + 6'd1;
        end
        if (uop.dest == amx_pkg::DET_IDX) begin
          det_zero_q <= acc == '0;
        end
        k_q <= '0;
      end
      if (state_q == amx_pkg::ST_EMIT) begin
        k_q <= k_q + 4'd1;
      end
    end
  end

  // element store and adjugate store, one read port each
  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q[load_cnt_q] <= element_value_i;
    end
    rd_q   <= store_q[st_addr];
    rres_q <= res_q[res_addr];
    if (state_q == amx_pkg::ST_RDB) begin
      opa_q <= rd_q;
    end
    if (state_q == amx_pkg::ST_WB) begin
      if (uop.dest == amx_pkg::DET_IDX) begin
        det_q <= acc;
      end else begin
        res_q[uop.dest] <= acc;
      end
    end
  end

  // operand b: element, or the signed high / unsigned low limb of a cofactor
  always_comb begin
    opa = {opa_q[31], opa_q};
    unique case (uop.b_sel)
      amx_pkg::B_HI: opb = rres_q[64:32];
      amx_pkg::B_LO: opb = {1'b0, rres_q[31:0]};
      default:       opb = {rd_q[31], rd_q};
    endcase
  end

  amx_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .opa_i  (opa),
    .opb_i  (opb),
    .acc_o  (acc)
  );

  // odd entries get negated; cofactors scale by 2F, translation by F
  always_comb begin
    num_mag = rres_q[amx_pkg::ACC_W-1] ? amx_pkg::ACC_W'(-rres_q) : rres_q;
    det_mag = det_q[amx_pkg::ACC_W-1] ? amx_pkg::ACC_W'(-det_q) : det_q;
    num_neg = rres_q[amx_pkg::ACC_W-1] ^ k_q[0] ^ det_q[amx_pkg::ACC_W-1];
    num     = (k_q < amx_pkg::TRANS_IDX) ? (amx_pkg::num_t'(num_mag) << (2 * FRAC_BITS))
                                         : (amx_pkg::num_t'(num_mag) << FRAC_BITS);
    den     = amx_pkg::num_t'(det_mag);
  end

  amx_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .neg_i   (num_neg),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign inverse_value_o = det_zero_q ? 32'sd0 : $signed(quot);
  assign is_last_o       = result_valid_o && (k_q == amx_pkg::LAST_IDX);
  assign singular_o      = det_zero_q;

  // checks
  ap_busy_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result without busy");
  ap_last_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_last_o |=> !busy) else $error("not idle after last result");
  ap_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && singular_o) |-> inverse_value_o == 32'sd0)
    else $error("nonzero value on singular result");
  ap_twelfth_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && load_cnt_q == amx_pkg::LAST_IDX) |=> busy)
    else $error("not busy after twelfth request");

endmodule
`default_nettype wire
